// ----- hdl/ufs_pkg.sv -----
// Package for the URL field splitter: parse states, field tags, character
// constants and the result record passed between the parser and output stage.
// No dependencies.
package ufs_pkg;

	// Parse states of the URL automaton.
	typedef enum logic [2:0] {
		ST_LEAD   = 3'd0,
		ST_COLON1 = 3'd1,
		ST_SLASH1 = 3'd2,
		ST_SLASH2 = 3'd3,
		ST_HOST   = 3'd4,
		ST_HCOLON = 3'd5,
		ST_PORT   = 3'd6,
		ST_PATH   = 3'd7
	} parse_state_t;

	// Field tags attached to each character.
	typedef enum logic [2:0] {
		TAG_LEAD = 3'd0,
		TAG_HOST = 3'd1,
		TAG_PATH = 3'd2,
		TAG_DROP = 3'd3,
		TAG_PORT = 3'd4
	} field_tag_t;

	localparam int unsigned PORT_W = 16;
	localparam int unsigned PROD_W = PORT_W + 4;

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [PORT_W-1:0] PORT_MAX = {PORT_W{1'b1}};

	// One tagged character with the parse status after it.
	typedef struct packed {
		logic [7:0]        char_val;
		field_tag_t        tag;
		logic              lead_host;
		logic [PORT_W-1:0] port_val;
		logic              port_seen;
		logic              last;
	} result_t;

	// True for the bytes '0' to '9' only.
	function automatic logic is_dec_digit(input logic [7:0] c);
		is_dec_digit = (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

endpackage

// ----- hdl/url_field_splitter.sv -----
// URL field splitter top level: input register, parser and output register.
// Depends on ufs_pkg, ufs_parse and ufs_out_stage.
//
// Usage: a URL enters one byte per transaction on the input channel
// (in_valid, in_stall, char_in, end_of_text); end_of_text marks its last
// byte. Each byte gives exactly one result transaction on the output channel
// (out_valid, out_stall, char_out, field_tag, leading_is_host, port_value,
// port_present, end_out): the byte echoed, its field tag and the parse status
// after it.
// The byte is captured in the input register at its transaction and passes
// through the parser into the result register, which drives the output
// ports. Throughput is one byte per cycle while the receiver does not stall;
// the parser state is a single register loop, so consecutive bytes follow
// with no gap.
// When the receiver stalls, the result register holds its transaction and
// the input register still takes one more byte; in_stall rises only when
// both are full. After the byte marked end_of_text the parse state returns
// to reset, so the next byte starts a new URL.
// Reset clears both valid flags and the parse state; no transaction is
// pending after reset.
module url_field_splitter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_in,
	input  logic        end_of_text,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  char_out,
	output logic [2:0]  field_tag,
	output logic        leading_is_host,
	output logic [15:0] port_value,
	output logic        port_present,
	output logic        end_out
);
	import ufs_pkg::*;

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       end_s1;
	logic       s2_ready;
	logic       fire;
	result_t    res;
	result_t    res_s2;

	// Input register is blocked only while full and unable to move on.
	assign in_stall = valid_s1 && !s2_ready;
	assign fire     = valid_s1 && s2_ready;

	// Input register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1 <= char_in;
			end_s1  <= end_of_text;
		end
	end

	ufs_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.char_s1 (char_s1),
		.end_s1  (end_s1),
		.res     (res)
	);

	ufs_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.res       (res),
		.out_stall (out_stall),
		.ready     (s2_ready),
		.valid_s2  (out_valid),
		.res_s2    (res_s2)
	);

	// Result fields onto the output ports.
	assign char_out        = res_s2.char_val;
	assign field_tag       = res_s2.tag;
	assign leading_is_host = res_s2.lead_host;
	assign port_value      = res_s2.port_val;
	assign port_present    = res_s2.port_seen;
	assign end_out         = res_s2.last;

endmodule

// ----- hdl/ufs_parse.sv -----
// Parser stage of the URL field splitter: the automaton state registers and
// the combinational tagging and port accumulation logic. Depends on ufs_pkg.
module ufs_parse (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fire,
	input  logic [7:0]      char_s1,
	input  logic            end_s1,
	output ufs_pkg::result_t res
);
	import ufs_pkg::*;

	parse_state_t      state_q, state_d;
	logic [PORT_W-1:0] port_q, port_d;
	logic              seen_q, seen_d;
	logic              lead_host_q, lead_host_d;
	field_tag_t        tag;
	logic              digit;
	logic [7:0]        diff;
	logic [3:0]        digit_val;
	logic [PROD_W-1:0] prod;

	// Digit value and the decimal shift-add of the running port.
	assign digit     = is_dec_digit(char_s1);
	assign diff      = char_s1 - CH_ZERO;
	assign digit_val = diff[3:0];
	assign prod      = {1'b0, port_q, 3'b000} + {3'b000, port_q, 1'b0}
		+ {{(PROD_W-4){1'b0}}, digit_val};

	// Next state and tag for the current character.
	always_comb begin
		state_d     = state_q;
		port_d      = port_q;
		seen_d      = seen_q;
		lead_host_d = lead_host_q;
		tag         = TAG_DROP;
		unique case (state_q)
			ST_LEAD: begin
				if (char_s1 == CH_COLON) begin
					state_d = ST_COLON1;
					tag     = TAG_DROP;
				end else if (char_s1 == CH_DOT) begin
					lead_host_d = 1'b1;
					state_d     = ST_HOST;
					tag         = TAG_HOST;
				end else begin
					tag = TAG_LEAD;
				end
			end
			ST_COLON1: begin
				if (digit) begin
					lead_host_d = 1'b1;
					port_d      = {{(PORT_W-4){1'b0}}, digit_val};
					seen_d      = 1'b1;
					state_d     = ST_PORT;
					tag         = TAG_PORT;
				end else begin
					if (char_s1 == CH_SLASH) begin
						state_d = ST_SLASH1;
					end
					tag = TAG_DROP;
				end
			end
			ST_SLASH1: begin
				if (char_s1 == CH_SLASH) begin
					state_d = ST_SLASH2;
				end
				tag = TAG_DROP;
			end
			ST_SLASH2: begin
				state_d = ST_HOST;
				tag     = TAG_HOST;
			end
			ST_HOST: begin
				if (char_s1 == CH_COLON) begin
					state_d = ST_HCOLON;
					tag     = TAG_DROP;
				end else if (char_s1 == CH_SLASH) begin
					state_d = ST_PATH;
					tag     = TAG_PATH;
				end else begin
					tag = TAG_HOST;
				end
			end
			ST_HCOLON: begin
				if (digit) begin
					port_d  = {{(PORT_W-4){1'b0}}, digit_val};
					seen_d  = 1'b1;
					state_d = ST_PORT;
					tag     = TAG_PORT;
				end else begin
					tag = TAG_DROP;
				end
			end
			ST_PORT: begin
				if (digit) begin
					port_d = (prod > {{(PROD_W-PORT_W){1'b0}}, PORT_MAX})
						? PORT_MAX : prod[PORT_W-1:0];
					tag    = TAG_PORT;
				end else begin
					state_d = ST_PATH;
					tag     = TAG_PATH;
				end
			end
			ST_PATH: begin
				tag = TAG_PATH;
			end
		endcase
	end

	// Result fields show the status after this character.
	always_comb begin
		res.char_val  = char_s1;
		res.tag       = tag;
		res.lead_host = lead_host_d;
		res.port_val  = port_d;
		res.port_seen = seen_d;
		res.last      = end_s1;
	end

	// State registers; the final character of a URL returns them to reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LEAD;
			port_q      <= '0;
			seen_q      <= 1'b0;
			lead_host_q <= 1'b0;
		end else if (fire) begin
			if (end_s1) begin
				state_q     <= ST_LEAD;
				port_q      <= '0;
				seen_q      <= 1'b0;
				lead_host_q <= 1'b0;
			end else begin
				state_q     <= state_d;
				port_q      <= port_d;
				seen_q      <= seen_d;
				lead_host_q <= lead_host_d;
			end
		end
	end

endmodule

// ----- hdl/ufs_out_stage.sv -----
// Output register of the URL field splitter: holds one tagged result until the
// receiver takes it. Depends on ufs_pkg.
module ufs_out_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fire,
	input  ufs_pkg::result_t res,
	input  logic            out_stall,
	output logic            ready,
	output logic            valid_s2,
	output ufs_pkg::result_t res_s2
);
	import ufs_pkg::*;

	// The register can load when empty or when its transaction leaves now.
	assign ready = !valid_s2 || !out_stall;

	// Valid flag of the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready) begin
			valid_s2 <= fire;
		end
	end

	// Result payload, loaded only with a new transaction.
	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res;
		end
	end

endmodule

// ----- hdl/ufs_checker.sv -----
// Port-level checks for the URL field splitter, and the bind that attaches
// them to the top level. Depends on ufs_pkg and url_field_splitter.
module ufs_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [7:0]  char_out,
	input  logic [2:0]  field_tag,
	input  logic [15:0] port_value,
	input  logic        port_present,
	input  logic        end_out
);
	import ufs_pkg::*;

	// A stalled result transaction stays valid.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result transaction dropped while stalled");

	// A stalled result keeps its char, tag, port value and end flag.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(char_out) && $stable(field_tag)
			&& $stable(port_value) && $stable(end_out))
		else $error("result payload changed while stalled");

	// A port digit or a non-zero port value implies a port has been seen.
	a_port_seen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (field_tag == TAG_PORT || port_value != '0) |-> port_present)
		else $error("port value shown without port_present");

	// A result that directly follows the taken end of a URL shows a cleared port.
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && end_out |=>
			!out_valid || (!port_present && port_value == '0))
		else $error("port status not cleared after end of URL");

endmodule

bind url_field_splitter ufs_checker u_ufs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.char_out     (char_out),
	.field_tag    (field_tag),
	.port_value   (port_value),
	.port_present (port_present),
	.end_out      (end_out)
);

// ----- verif/tb_top.sv -----
// Self-checking testbench for url_field_splitter: directed and random URLs,
// predicted byte by byte and compared with every result transaction.
// Depends on ufs_pkg and the url_field_splitter RTL.
module tb_top;
	import ufs_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int ITEMS_PER_PHASE = 510;
	localparam int DRAIN_CYCLES = 8;

	// Expected content of one result transaction.
	typedef struct {
		logic [7:0]  ch;
		field_tag_t  tag;
		logic        lead_host;
		logic [15:0] port;
		logic        seen;
		logic        last;
	} char_result_t;

	// One row of the directed stimulus; the expected fields count only when typed is set.
	typedef struct packed {
		logic [7:0]  ch;
		logic        eot;
		logic        typed;
		field_tag_t  tag;
		logic        lead_host;
		logic [15:0] port;
		logic        seen;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  char_in = 8'd0;
	logic        end_of_text = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  char_out;
	logic [2:0]  field_tag;
	logic        leading_is_host;
	logic [15:0] port_value;
	logic        port_present;
	logic        end_out;

	// Predictor state, mirroring the parser.
	parse_state_t url_state;
	logic [15:0]  port_acc;
	logic         port_got;
	logic         lead_host_flag;

	char_result_t expected_q[$];
	logic [7:0]   url_bytes[$];
	stim_row_t    dir_rows[0:23];
	int           gap_pct = 0;
	int           stall_pct = 0;
	int           error_count = 0;
	int           results_seen = 0;
	int           quiet_cycles = 0;
	int           phase_items = 0;

	url_field_splitter dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.char_in         (char_in),
		.end_of_text     (end_of_text),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.char_out        (char_out),
		.field_tag       (field_tag),
		.leading_is_host (leading_is_host),
		.port_value      (port_value),
		.port_present    (port_present),
		.end_out         (end_out)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Put the URL automaton back to its state after reset.
	function automatic void clear_url_state();
		url_state = ST_LEAD;
		port_acc = 16'd0;
		port_got = 1'b0;
		lead_host_flag = 1'b0;
	endfunction

	// Tag one byte, advance the automaton and return the result it should produce.
	function automatic char_result_t split_char(input logic [7:0] c, input logic eot);
		char_result_t res;
		logic dig;
		int acc;
		dig = (c >= CH_ZERO) && (c <= CH_NINE);
		res.tag = TAG_DROP;
		case (url_state)
			ST_LEAD: begin
				if (c == CH_COLON) begin
					url_state = ST_COLON1;
				end else if (c == CH_DOT) begin
					lead_host_flag = 1'b1;
					url_state = ST_HOST;
					res.tag = TAG_HOST;
				end else begin
					res.tag = TAG_LEAD;
				end
			end
			ST_COLON1: begin
				// A digit straight after the first colon makes the leading segment a host.
				if (dig) begin
					lead_host_flag = 1'b1;
					port_acc = {8'd0, c - CH_ZERO};
					port_got = 1'b1;
					url_state = ST_PORT;
					res.tag = TAG_PORT;
				end else if (c == CH_SLASH) begin
					url_state = ST_SLASH1;
				end
			end
			ST_SLASH1: begin
				if (c == CH_SLASH)
					url_state = ST_SLASH2;
			end
			ST_SLASH2: begin
				url_state = ST_HOST;
				res.tag = TAG_HOST;
			end
			ST_HOST: begin
				if (c == CH_COLON) begin
					url_state = ST_HCOLON;
				end else if (c == CH_SLASH) begin
					url_state = ST_PATH;
					res.tag = TAG_PATH;
				end else begin
					res.tag = TAG_HOST;
				end
			end
			ST_HCOLON: begin
				if (dig) begin
					port_acc = {8'd0, c - CH_ZERO};
					port_got = 1'b1;
					url_state = ST_PORT;
					res.tag = TAG_PORT;
				end
			end
			ST_PORT: begin
				// Decimal accumulation, saturating at the largest port.
				if (dig) begin
					acc = int'(port_acc) * 10 + int'(c) - int'(CH_ZERO);
					port_acc = (acc > int'(PORT_MAX)) ? PORT_MAX : acc[15:0];
					res.tag = TAG_PORT;
				end else begin
					url_state = ST_PATH;
					res.tag = TAG_PATH;
				end
			end
			default: begin
				res.tag = TAG_PATH;
			end
		endcase
		res.ch = c;
		res.lead_host = lead_host_flag;
		res.port = port_acc;
		res.seen = port_got;
		res.last = eot;
		if (eot)
			clear_url_state();
		return res;
	endfunction

	// Print one line per mismatch and count it.
	task automatic report_mismatch(input string msg);
		$display("mismatch: %s", msg);
		error_count++;
	endtask

	// Offer one byte, with random idle cycles in front, and wait for the transaction.
	task automatic send_char(input logic [7:0] c, input logic eot);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		char_in <= c;
		end_of_text <= eot;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		phase_items++;
	endtask

	// Hold the sender off until every outstanding result has been received.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] host_char();
		case ($urandom_range(5))
			0: return CH_DOT;
			1: return CH_ZERO + 8'($urandom_range(9));
			default: return 8'h61 + 8'($urandom_range(25));
		endcase
	endfunction

	// Build one URL: mostly well formed with random parts, the rest noise or truncated.
	task automatic build_url();
		int form;
		int n;
		url_bytes.delete();
		form = $urandom_range(9);
		if (form >= 8) begin
			n = $urandom_range(1, 12);
			repeat (n) begin
				case ($urandom_range(5))
					0: url_bytes.push_back(CH_COLON);
					1: url_bytes.push_back(CH_SLASH);
					2: url_bytes.push_back(CH_DOT);
					3: url_bytes.push_back(CH_ZERO + 8'($urandom_range(9)));
					default: url_bytes.push_back(8'($urandom_range(255)));
				endcase
			end
		end else begin
			if ($urandom_range(1)) begin
				n = $urandom_range(1, 5);
				repeat (n)
					url_bytes.push_back(8'h61 + 8'($urandom_range(25)));
				url_bytes.push_back(CH_COLON);
				if ($urandom_range(3) != 0) begin
					url_bytes.push_back(CH_SLASH);
					url_bytes.push_back(CH_SLASH);
				end else begin
					url_bytes.push_back(host_char());
				end
			end
			n = $urandom_range(1, 8);
			repeat (n)
				url_bytes.push_back(host_char());
			if ($urandom_range(1)) begin
				url_bytes.push_back(CH_COLON);
				n = $urandom_range(0, 6);
				repeat (n)
					url_bytes.push_back(CH_ZERO + 8'($urandom_range(9)));
			end
			if ($urandom_range(1)) begin
				url_bytes.push_back(CH_SLASH);
				n = $urandom_range(0, 6);
				repeat (n)
					url_bytes.push_back(8'($urandom_range(255)));
			end
			// A broken URL: cut short at a random point.
			if (form == 7) begin
				n = $urandom_range(1, url_bytes.size());
				while (url_bytes.size() > n)
					void'(url_bytes.pop_back());
			end
		end
	endtask

	// Send random URLs until the phase has its share of bytes.
	task automatic run_random(input int item_count);
		int i;
		phase_items = 0;
		while (phase_items < item_count) begin
			build_url();
			for (i = 0; i < url_bytes.size(); i++) begin
				send_char(url_bytes[i], i == url_bytes.size() - 1);
				expected_q.push_back(split_char(url_bytes[i], i == url_bytes.size() - 1));
			end
		end
	endtask

	// Check each result transaction against the oldest expectation; watch for a hang.
	always @(posedge clk) begin : result_check
		char_result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					report_mismatch($sformatf("result %0d arrived with nothing pending",
						results_seen));
				end else begin
					want = expected_q.pop_front();
					if (char_out !== want.ch)
						report_mismatch($sformatf("result %0d char_out: got %0h, expected %0h",
							results_seen, char_out, want.ch));
					if (field_tag !== want.tag)
						report_mismatch($sformatf("result %0d field_tag: got %0d, expected %0d",
							results_seen, field_tag, want.tag));
					if (leading_is_host !== want.lead_host)
						report_mismatch($sformatf("result %0d leading_is_host: got %0d, expected %0d",
							results_seen, leading_is_host, want.lead_host));
					if (port_value !== want.port)
						report_mismatch($sformatf("result %0d port_value: got %0d, expected %0d",
							results_seen, port_value, want.port));
					if (port_present !== want.seen)
						report_mismatch($sformatf("result %0d port_present: got %0d, expected %0d",
							results_seen, port_present, want.seen));
					if (end_out !== want.last)
						report_mismatch($sformatf("result %0d end_out: got %0d, expected %0d",
							results_seen, end_out, want.last));
				end
				results_seen++;
				quiet_cycles = 0;
			end else if (in_valid && !in_stall) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog expired after %0d idle cycles", quiet_cycles);
				$display("status: fail");
				$finish;
			end
		end
	end

	// Receiver stalls at random at the current rate.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	initial begin : stimulus
		char_result_t want;
		int i;
		clear_url_state();

		// Directed URLs: byte extremes, every parse state, saturation, leading zero port.
		dir_rows[0]  = '{8'h00,    1'b0, 1'b1, TAG_LEAD, 1'b0, 16'd0,     1'b0};
		dir_rows[1]  = '{8'hFF,    1'b0, 1'b1, TAG_LEAD, 1'b0, 16'd0,     1'b0};
		dir_rows[2]  = '{CH_COLON, 1'b0, 1'b1, TAG_DROP, 1'b0, 16'd0,     1'b0};
		dir_rows[3]  = '{8'h78,    1'b0, 1'b0, TAG_DROP, 1'b0, 16'd0,     1'b0};
		dir_rows[4]  = '{CH_SLASH, 1'b0, 1'b0, TAG_DROP, 1'b0, 16'd0,     1'b0};
		dir_rows[5]  = '{CH_SLASH, 1'b0, 1'b0, TAG_DROP, 1'b0, 16'd0,     1'b0};
		dir_rows[6]  = '{8'h68,    1'b0, 1'b0, TAG_DROP, 1'b0, 16'd0,     1'b0};
		dir_rows[7]  = '{CH_COLON, 1'b0, 1'b0, TAG_DROP, 1'b0, 16'd0,     1'b0};
		dir_rows[8]  = '{8'h71,    1'b0, 1'b0, TAG_DROP, 1'b0, 16'd0,     1'b0};
		dir_rows[9]  = '{CH_NINE,  1'b0, 1'b0, TAG_DROP, 1'b0, 16'd0,     1'b0};
		dir_rows[10] = '{CH_NINE,  1'b0, 1'b0, TAG_DROP, 1'b0, 16'd0,     1'b0};
		dir_rows[11] = '{CH_NINE,  1'b0, 1'b0, TAG_DROP, 1'b0, 16'd0,     1'b0};
		dir_rows[12] = '{CH_NINE,  1'b0, 1'b0, TAG_DROP, 1'b0, 16'd0,     1'b0};
		dir_rows[13] = '{CH_NINE,  1'b0, 1'b1, TAG_PORT, 1'b0, 16'd65535, 1'b1};
		dir_rows[14] = '{CH_ZERO,  1'b0, 1'b1, TAG_PORT, 1'b0, 16'd65535, 1'b1};
		dir_rows[15] = '{8'h61,    1'b0, 1'b0, TAG_DROP, 1'b0, 16'd0,     1'b0};
		dir_rows[16] = '{CH_SLASH, 1'b1, 1'b0, TAG_DROP, 1'b0, 16'd0,     1'b0};
		dir_rows[17] = '{8'h61,    1'b0, 1'b1, TAG_LEAD, 1'b0, 16'd0,     1'b0};
		dir_rows[18] = '{CH_DOT,   1'b0, 1'b1, TAG_HOST, 1'b1, 16'd0,     1'b0};
		dir_rows[19] = '{CH_SLASH, 1'b0, 1'b0, TAG_DROP, 1'b0, 16'd0,     1'b0};
		dir_rows[20] = '{8'hFF,    1'b1, 1'b0, TAG_DROP, 1'b0, 16'd0,     1'b0};
		dir_rows[21] = '{8'h61,    1'b0, 1'b0, TAG_DROP, 1'b0, 16'd0,     1'b0};
		dir_rows[22] = '{CH_COLON, 1'b0, 1'b0, TAG_DROP, 1'b0, 16'd0,     1'b0};
		dir_rows[23] = '{CH_ZERO,  1'b1, 1'b1, TAG_PORT, 1'b1, 16'd0,     1'b1};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Phase one: sender idles a little, receiver stalls a lot.
		gap_pct = 21;
		stall_pct = 76;
		for (i = 0; i < 24; i++) begin
			send_char(dir_rows[i].ch, dir_rows[i].eot);
			want = split_char(dir_rows[i].ch, dir_rows[i].eot);
			if (dir_rows[i].typed) begin
				want.tag = dir_rows[i].tag;
				want.lead_host = dir_rows[i].lead_host;
				want.port = dir_rows[i].port;
				want.seen = dir_rows[i].seen;
			end
			expected_q.push_back(want);
		end
		run_random(ITEMS_PER_PHASE);
		drain_results();

		// Phase two: the other way round.
		gap_pct = 76;
		stall_pct = 21;
		run_random(ITEMS_PER_PHASE);
		drain_results();

		// Phase three: full rate on both sides.
		gap_pct = 0;
		stall_pct = 0;
		run_random(ITEMS_PER_PHASE);

		in_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
